// ===== design/opi_pkg.sv =====
`default_nettype none
package opi_pkg;

   localparam int POS_W = 32;
   localparam int TRIG_ITER = 16;
   localparam int ATAN_LEN = 24;
   localparam int CORDIC_STEPS = (TRIG_ITER < ATAN_LEN) ? TRIG_ITER : ATAN_LEN;
   localparam int ITER_W = $clog2(CORDIC_STEPS);

   localparam int TRIG_W = 34;
   localparam int ANG_W = 33;
   localparam logic signed [TRIG_W-1:0] GAIN_INV = TRIG_W'(652032874);
   localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(64'h4000_0000);
   localparam logic signed [ANG_W-1:0] HALF_TURN = ANG_W'(64'h8000_0000);

   localparam int MUL_W = 16 + TRIG_W;
   localparam int MAG_W = 47;
   localparam int M_W = MAG_W + 16;
   localparam logic [M_W:0] HALF_DIV = (M_W + 1)'(64'd2097152000000);
   localparam int T_W = M_W + 1 - 28;

   // divide by 15625 as a multiply by ceil(2^50 / 15625), exact below 2^T_W
   localparam int RCP_W = 37;
   localparam logic [RCP_W-1:0] STEP_RCP = 37'd72057594038;
   localparam int RCP_SHIFT = 50;
   localparam int RCP_LO_W = 18;
   localparam int HALF_T = T_W / 2;
   localparam int PP_W = (T_W - HALF_T) + (RCP_W - RCP_LO_W);
   localparam int ACC_W = T_W + RCP_W;
   localparam int Q_W = ACC_W - RCP_SHIFT;
   localparam int MUL_STEPS = 4;
   localparam int DCNT_W = $clog2(MUL_STEPS + 1);

   localparam int SUM_W = ((POS_W > T_W + 1) ? POS_W : T_W + 1) + 1;
   localparam logic signed [SUM_W-1:0] POS_HI =
      $signed({{(SUM_W - POS_W + 1){1'b0}}, {(POS_W - 1){1'b1}}});
   localparam logic signed [SUM_W-1:0] POS_LO = ~POS_HI;

   typedef struct packed {
      logic signed [15:0] speed;
      logic signed [15:0] heading;
      logic [15:0]        elapsed_time;
      logic signed [15:0] turn_rate;
   } opi_item_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_TRIG  = 5'b00010,
      ST_MUL   = 5'b00100,
      ST_ROUND = 5'b01000,
      ST_DIV   = 5'b10000
   } opi_state_type;

   function automatic logic signed [ANG_W-1:0] atan_turn(input logic [4:0] idx);
      logic signed [ANG_W-1:0] r;
      case (idx)
         5'd0: r = ANG_W'(32'h20000000);
         5'd1: r = ANG_W'(32'h12E4051E);
         5'd2: r = ANG_W'(32'h09FB385B);
         5'd3: r = ANG_W'(32'h051111D4);
         5'd4: r = ANG_W'(32'h028B0D43);
         5'd5: r = ANG_W'(32'h0145D7E1);
         5'd6: r = ANG_W'(32'h00A2F61E);
         5'd7: r = ANG_W'(32'h00517C55);
         5'd8: r = ANG_W'(32'h0028BE53);
         5'd9: r = ANG_W'(32'h00145F2F);
         5'd10: r = ANG_W'(32'h000A2F98);
         5'd11: r = ANG_W'(32'h000517CC);
         5'd12: r = ANG_W'(32'h00028BE6);
         5'd13: r = ANG_W'(32'h000145F3);
         5'd14: r = ANG_W'(32'h0000A2FA);
         5'd15: r = ANG_W'(32'h0000517D);
         5'd16: r = ANG_W'(32'h000028BE);
         5'd17: r = ANG_W'(32'h0000145F);
         5'd18: r = ANG_W'(32'h00000A30);
         5'd19: r = ANG_W'(32'h00000518);
         5'd20: r = ANG_W'(32'h0000028C);
         5'd21: r = ANG_W'(32'h00000146);
         5'd22: r = ANG_W'(32'h000000A3);
         5'd23: r = ANG_W'(32'h00000051);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== design/opi_if.sv =====
`default_nettype none
interface opi_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] speed;
   logic signed [15:0] yaw_rate;
   logic signed [15:0] heading;
   logic [15:0]        elapsed_time;

   modport source (output valid, speed, yaw_rate, heading, elapsed_time, input ready);
   modport sink (input valid, speed, yaw_rate, heading, elapsed_time, output ready);
endinterface

interface opi_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [15:0] vel_x;
   logic signed [15:0] vel_y;
   logic signed [15:0] turn_rate;
   logic signed [15:0] quat_z;
   logic signed [15:0] quat_w;

   modport source (output valid, pos_x, pos_y, vel_x, vel_y, turn_rate, quat_z, quat_w,
                   input ready);
   modport sink (input valid, pos_x, pos_y, vel_x, vel_y, turn_rate, quat_z, quat_w,
                 output ready);
endinterface
`default_nettype wire

// ===== design/planar_odometry_integrator_top.sv =====
// a taken request passes, with the back end free, through dispatch, the cordic rotations
// until done, the multiply, the rounding, the reciprocal multiply and the result load
// the shared back-end sequencer works on one request at a time, taking the next when idle;
// a two-entry queue takes requests while the back end works, a held result stalls it
// reset: synchronous, active high; clears position and held heading to zero
`default_nettype none
module planar_odometry_integrator_top (
   input  wire logic clock,
   input  wire logic reset,
   opi_req_if.sink   req_bus,
   opi_rsp_if.source rsp_bus
);

   opi_pkg::opi_item_type item;
   logic                  item_valid;
   logic                  item_pop;

   opi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop)
   );

   opi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .rsp_bus    (rsp_bus)
   );

endmodule
`default_nettype wire

// ===== design/opi_front.sv =====
`default_nettype none
module opi_front (
   input  wire logic               clock,
   input  wire logic               reset,
   opi_req_if.sink                 req_bus,
   output opi_pkg::opi_item_type   item,
   output logic                    item_valid,
   input  wire logic               item_pop
);

   opi_pkg::opi_item_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   opi_pkg::opi_item_type new_item;

   assign req_bus.ready = (count_ff != 2'd2);
   assign push = req_bus.valid && req_bus.ready;
   assign item_valid = (count_ff != 2'd0);
   assign item = slot_ff[rd_ptr_ff];

   always_comb begin
      new_item.speed = req_bus.speed;
      new_item.heading = req_bus.heading;
      new_item.elapsed_time = req_bus.elapsed_time;
      // negation saturates on the most negative rate
      if (req_bus.yaw_rate == 16'sh8000) begin
         new_item.turn_rate = 16'sh7FFF;
      end else begin
         new_item.turn_rate = -req_bus.yaw_rate;
      end
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = item_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(push) - 2'(item_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule
`default_nettype wire

// ===== design/opi_cordic.sv =====
`default_nettype none
module opi_cordic (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic signed [opi_pkg::ANG_W-1:0]   angle,
   output logic                                    done,
   output logic signed [opi_pkg::TRIG_W-1:0]       cos_out,
   output logic signed [opi_pkg::TRIG_W-1:0]       sin_out
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [opi_pkg::ITER_W-1:0]         cnt_ff, cnt_in;
   logic                               flip_ff, flip_in;
   logic signed [opi_pkg::TRIG_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [opi_pkg::ANG_W-1:0]   z_ff, z_in;
   logic signed [opi_pkg::TRIG_W-1:0]  xs, ys;
   logic signed [opi_pkg::ANG_W-1:0]   at;

   assign done = done_ff;
   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      flip_in = flip_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      xs = x_ff >>> cnt_ff;
      ys = y_ff >>> cnt_ff;
      at = opi_pkg::atan_turn(5'(cnt_ff));
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         x_in = opi_pkg::GAIN_INV;
         y_in = '0;
         // fold to within a quarter turn
         if (angle > opi_pkg::QUARTER_TURN) begin
            z_in = angle - opi_pkg::HALF_TURN;
            flip_in = 1'b1;
         end else if (angle < -opi_pkg::QUARTER_TURN) begin
            z_in = angle + opi_pkg::HALF_TURN;
            flip_in = 1'b1;
         end else begin
            z_in = angle;
            flip_in = 1'b0;
         end
      end else if (busy_ff) begin
         if (!z_ff[opi_pkg::ANG_W-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == opi_pkg::ITER_W'(opi_pkg::CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      flip_ff <= flip_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

endmodule
`default_nettype wire

// ===== design/opi_back.sv =====
`default_nettype none
module opi_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  opi_pkg::opi_item_type   item,
   input  wire logic               item_valid,
   output logic                    item_pop,
   opi_rsp_if.source               rsp_bus
);

   opi_pkg::opi_state_type state_ff, state_in;
   opi_pkg::opi_item_type  cur_ff;

   logic signed [opi_pkg::POS_W-1:0]  pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [15:0]                held_ff, held_in;

   logic                              trig_start;
   logic signed [opi_pkg::ANG_W-1:0]  ang_a, ang_b;
   logic                              done_a, done_b;
   logic signed [opi_pkg::TRIG_W-1:0] ca, sa, cb, sb;

   logic signed [opi_pkg::MUL_W-1:0]  sc_x_ff, sc_y_ff, spd_ext, ca_ext, sa_ext;
   logic signed [opi_pkg::MUL_W-1:0]  sc_x_in, sc_y_in, mag_x, mag_y;
   logic [opi_pkg::M_W-1:0]           m_x_ff, m_y_ff;
   logic [opi_pkg::M_W:0]             mh_x, mh_y;
   logic                              neg_x_ff, neg_y_ff;
   logic [opi_pkg::T_W-1:0]           t_x_ff, t_y_ff;
   logic [opi_pkg::T_W-opi_pkg::HALF_T-1:0]         op_tx, op_ty;
   logic [opi_pkg::RCP_W-opi_pkg::RCP_LO_W-1:0]     op_r;
   logic [opi_pkg::PP_W-1:0]          pp_x, pp_y;
   logic [opi_pkg::ACC_W-1:0]         acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic [opi_pkg::Q_W-1:0]           q_x, q_y;
   logic [opi_pkg::DCNT_W-1:0]        dcnt_ff, dcnt_in;

   logic signed [opi_pkg::MUL_W:0]    vx_r, vy_r;
   logic signed [opi_pkg::TRIG_W:0]   qz_r, qw_r;
   logic signed [15:0]                vel_x_ff, vel_y_ff, quat_z_ff, quat_w_ff;
   logic signed [15:0]                vel_x_in, vel_y_in, quat_z_in, quat_w_in;

   logic signed [opi_pkg::SUM_W-1:0]  dx, dy, sx, sy;

   logic                              rsp_valid_ff, rsp_valid_in, rsp_load;
   logic signed [31:0]                rsp_pos_x_ff, rsp_pos_y_ff;
   logic signed [15:0]                rsp_vel_x_ff, rsp_vel_y_ff, rsp_turn_ff;
   logic signed [15:0]                rsp_qz_ff, rsp_qw_ff;

   assign item_pop = (state_ff == opi_pkg::ST_IDLE) && item_valid;
   assign trig_start = item_pop;
   assign ang_a = opi_pkg::ANG_W'($signed({held_ff, 16'h0000}));
   assign ang_b = -opi_pkg::ANG_W'($signed({item.heading, 15'h0000}));

   opi_cordic u_cordic_a (
      .clock   (clock),
      .reset   (reset),
      .start   (trig_start),
      .angle   (ang_a),
      .done    (done_a),
      .cos_out (ca),
      .sin_out (sa)
   );

   opi_cordic u_cordic_b (
      .clock   (clock),
      .reset   (reset),
      .start   (trig_start),
      .angle   (ang_b),
      .done    (done_b),
      .cos_out (cb),
      .sin_out (sb)
   );

   function automatic logic signed [15:0] sat16(input logic signed [opi_pkg::MUL_W:0] v);
      logic signed [opi_pkg::MUL_W:0] s;
      logic signed [15:0]             r;
      s = v >>> 30;
      if (s > 32767) begin
         r = 16'sh7FFF;
      end else if (s < -32768) begin
         r = 16'sh8000;
      end else begin
         r = s[15:0];
      end
      return r;
   endfunction

   function automatic logic signed [15:0] q14(input logic signed [opi_pkg::TRIG_W:0] v);
      logic signed [opi_pkg::TRIG_W:0] s;
      logic signed [15:0]              r;
      s = v >>> 16;
      if (s > 16384) begin
         r = 16'sd16384;
      end else if (s < -16384) begin
         r = -16'sd16384;
      end else begin
         r = s[15:0];
      end
      return r;
   endfunction

   function automatic logic signed [opi_pkg::POS_W-1:0] sat_pos(
      input logic signed [opi_pkg::SUM_W-1:0] v);
      logic signed [opi_pkg::SUM_W-1:0] c;
      if (v > opi_pkg::POS_HI) begin
         c = opi_pkg::POS_HI;
      end else if (v < opi_pkg::POS_LO) begin
         c = opi_pkg::POS_LO;
      end else begin
         c = v;
      end
      return c[opi_pkg::POS_W-1:0];
   endfunction

   function automatic logic [opi_pkg::ACC_W-1:0] place_pp(
      input logic [opi_pkg::PP_W-1:0] pp, input logic [1:0] sel);
      logic [opi_pkg::ACC_W-1:0] r;
      case (sel)
         2'd0: r = opi_pkg::ACC_W'(pp);
         2'd1: r = opi_pkg::ACC_W'(pp) << opi_pkg::RCP_LO_W;
         2'd2: r = opi_pkg::ACC_W'(pp) << opi_pkg::HALF_T;
         default: r = opi_pkg::ACC_W'(pp) << (opi_pkg::HALF_T + opi_pkg::RCP_LO_W);
      endcase
      return r;
   endfunction

   always_comb begin
      state_in = state_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      held_in = held_ff;
      dcnt_in = dcnt_ff;
      rsp_load = 1'b0;

      spd_ext = opi_pkg::MUL_W'(cur_ff.speed);
      ca_ext = opi_pkg::MUL_W'(ca);
      sa_ext = opi_pkg::MUL_W'(sa);
      sc_x_in = spd_ext * ca_ext;
      sc_y_in = -(spd_ext * sa_ext);

      vx_r = (opi_pkg::MUL_W + 1)'(sc_x_ff) + (opi_pkg::MUL_W + 1)'(32'sh2000_0000);
      vy_r = (opi_pkg::MUL_W + 1)'(sc_y_ff) + (opi_pkg::MUL_W + 1)'(32'sh2000_0000);
      vel_x_in = sat16(vx_r);
      vel_y_in = sat16(vy_r);
      qz_r = (opi_pkg::TRIG_W + 1)'(sb) + (opi_pkg::TRIG_W + 1)'(32'sh8000);
      qw_r = (opi_pkg::TRIG_W + 1)'(cb) + (opi_pkg::TRIG_W + 1)'(32'sh8000);
      quat_z_in = q14(qz_r);
      quat_w_in = q14(qw_r);

      mag_x = sc_x_ff[opi_pkg::MUL_W-1] ? -sc_x_ff : sc_x_ff;
      mag_y = sc_y_ff[opi_pkg::MUL_W-1] ? -sc_y_ff : sc_y_ff;

      mh_x = {1'b0, m_x_ff} + opi_pkg::HALF_DIV;
      mh_y = {1'b0, m_y_ff} + opi_pkg::HALF_DIV;

      // one partial product of t and the reciprocal a cycle
      op_tx = dcnt_ff[1] ? t_x_ff[opi_pkg::T_W-1:opi_pkg::HALF_T] :
              (opi_pkg::T_W - opi_pkg::HALF_T)'(t_x_ff[opi_pkg::HALF_T-1:0]);
      op_ty = dcnt_ff[1] ? t_y_ff[opi_pkg::T_W-1:opi_pkg::HALF_T] :
              (opi_pkg::T_W - opi_pkg::HALF_T)'(t_y_ff[opi_pkg::HALF_T-1:0]);
      op_r = dcnt_ff[0] ? opi_pkg::STEP_RCP[opi_pkg::RCP_W-1:opi_pkg::RCP_LO_W] :
             (opi_pkg::RCP_W - opi_pkg::RCP_LO_W)'(opi_pkg::STEP_RCP[opi_pkg::RCP_LO_W-1:0]);
      pp_x = opi_pkg::PP_W'(op_tx) * opi_pkg::PP_W'(op_r);
      pp_y = opi_pkg::PP_W'(op_ty) * opi_pkg::PP_W'(op_r);
      acc_x_in = acc_x_ff + place_pp(pp_x, dcnt_ff[1:0]);
      acc_y_in = acc_y_ff + place_pp(pp_y, dcnt_ff[1:0]);
      q_x = acc_x_ff[opi_pkg::ACC_W-1:opi_pkg::RCP_SHIFT];
      q_y = acc_y_ff[opi_pkg::ACC_W-1:opi_pkg::RCP_SHIFT];

      dx = neg_x_ff ? -opi_pkg::SUM_W'(q_x) : opi_pkg::SUM_W'(q_x);
      dy = neg_y_ff ? -opi_pkg::SUM_W'(q_y) : opi_pkg::SUM_W'(q_y);
      sx = opi_pkg::SUM_W'(pos_x_ff) + dx;
      sy = opi_pkg::SUM_W'(pos_y_ff) + dy;

      unique case (state_ff)
         opi_pkg::ST_IDLE: begin
            if (item_valid) begin
               state_in = opi_pkg::ST_TRIG;
            end
         end
         opi_pkg::ST_TRIG: begin
            if (done_a && done_b) begin
               state_in = opi_pkg::ST_MUL;
            end
         end
         opi_pkg::ST_MUL: begin
            state_in = opi_pkg::ST_ROUND;
         end
         opi_pkg::ST_ROUND: begin
            dcnt_in = '0;
            state_in = opi_pkg::ST_DIV;
         end
         opi_pkg::ST_DIV: begin
            if (dcnt_ff == opi_pkg::DCNT_W'(opi_pkg::MUL_STEPS)) begin
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  rsp_load = 1'b1;
                  pos_x_in = sat_pos(sx);
                  pos_y_in = sat_pos(sy);
                  held_in = cur_ff.heading;
                  state_in = opi_pkg::ST_IDLE;
               end
            end else begin
               dcnt_in = dcnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = opi_pkg::ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= opi_pkg::ST_IDLE;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         held_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         held_ff <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dcnt_ff <= dcnt_in;
      if (item_pop) begin
         cur_ff <= item;
      end
      if (state_ff == opi_pkg::ST_TRIG && done_a && done_b) begin
         sc_x_ff <= sc_x_in;
         sc_y_ff <= sc_y_in;
         quat_z_ff <= quat_z_in;
         quat_w_ff <= quat_w_in;
      end
      if (state_ff == opi_pkg::ST_MUL) begin
         vel_x_ff <= vel_x_in;
         vel_y_ff <= vel_y_in;
         neg_x_ff <= sc_x_ff[opi_pkg::MUL_W-1];
         neg_y_ff <= sc_y_ff[opi_pkg::MUL_W-1];
         m_x_ff <= opi_pkg::M_W'(mag_x[opi_pkg::MAG_W-1:0]) *
                   opi_pkg::M_W'(cur_ff.elapsed_time);
         m_y_ff <= opi_pkg::M_W'(mag_y[opi_pkg::MAG_W-1:0]) *
                   opi_pkg::M_W'(cur_ff.elapsed_time);
      end
      if (state_ff == opi_pkg::ST_ROUND) begin
         t_x_ff <= mh_x[opi_pkg::M_W:28];
         t_y_ff <= mh_y[opi_pkg::M_W:28];
         acc_x_ff <= '0;
         acc_y_ff <= '0;
      end else if (state_ff == opi_pkg::ST_DIV &&
                   dcnt_ff != opi_pkg::DCNT_W'(opi_pkg::MUL_STEPS)) begin
         acc_x_ff <= acc_x_in;
         acc_y_ff <= acc_y_in;
      end
      if (rsp_load) begin
         rsp_pos_x_ff <= 32'(pos_x_in);
         rsp_pos_y_ff <= 32'(pos_y_in);
         rsp_vel_x_ff <= vel_x_ff;
         rsp_vel_y_ff <= vel_y_ff;
         rsp_turn_ff <= cur_ff.turn_rate;
         rsp_qz_ff <= quat_z_ff;
         rsp_qw_ff <= quat_w_ff;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.pos_x = rsp_pos_x_ff;
   assign rsp_bus.pos_y = rsp_pos_y_ff;
   assign rsp_bus.vel_x = rsp_vel_x_ff;
   assign rsp_bus.vel_y = rsp_vel_y_ff;
   assign rsp_bus.turn_rate = rsp_turn_ff;
   assign rsp_bus.quat_z = rsp_qz_ff;
   assign rsp_bus.quat_w = rsp_qw_ff;

endmodule
`default_nettype wire

// ===== dv/planar_odometry_integrator_top_tb.sv =====
`default_nettype none
module planar_odometry_integrator_top_tb;

   typedef struct {
      logic signed [15:0] speed;
      logic signed [15:0] yaw_rate;
      logic signed [15:0] heading;
      logic [15:0]        elapsed_time;
   } odo_request_type;

   typedef struct {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [15:0] vel_x;
      logic signed [15:0] vel_y;
      logic signed [15:0] turn_rate;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
   } odo_pose_type;

   typedef struct {
      odo_request_type req;
      bit              known;
      odo_pose_type    pose;
   } odo_row_type;

   localparam longint STEP_DIVISOR = 64'd4194304000000;
   localparam longint CYCLE_LIMIT = 64'd1500000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   opi_req_if req_bus ();
   opi_rsp_if rsp_bus ();

   planar_odometry_integrator_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   longint track_x, track_y, track_heading;
   odo_pose_type pending_poses[$];
   int errors = 0;
   int send_idle_pct = 15;
   int recv_idle_pct = 54;
   bit hold_off = 1'b0;
   longint cycles = 0;

   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint limit(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic bit same_pose(odo_pose_type a, odo_pose_type b);
      return a.pos_x === b.pos_x && a.pos_y === b.pos_y && a.vel_x === b.vel_x &&
             a.vel_y === b.vel_y && a.turn_rate === b.turn_rate &&
             a.quat_z === b.quat_z && a.quat_w === b.quat_w;
   endfunction

   function automatic longint arctan_turns(int i);
      longint tbl[24] = '{
         64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
         64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
         64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
         64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
         64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
      return tbl[i];
   endfunction

   task automatic rotate_angle(input longint angle, output longint c, output longint s);
      longint x, y, z, nx;
      bit flip;
      x = 652032874;
      y = 0;
      z = angle;
      flip = 1'b0;
      if (z > 64'sh40000000) begin
         z -= 64'sh80000000;
         flip = 1'b1;
      end else if (z < -64'sh40000000) begin
         z += 64'sh80000000;
         flip = 1'b1;
      end
      for (int i = 0; i < opi_pkg::TRIG_ITER && i < 24; i++) begin
         if (z >= 0) begin
            nx = x - floor_shr(y, i);
            y = y + floor_shr(x, i);
            z -= arctan_turns(i);
         end else begin
            nx = x + floor_shr(y, i);
            y = y - floor_shr(x, i);
            z += arctan_turns(i);
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   function automatic longint travel_step(longint sc, longint dt);
      longint n;
      longint unsigned m, q;
      n = sc * dt;
      m = n < 0 ? -n : n;
      q = (m + STEP_DIVISOR / 2) / STEP_DIVISOR;
      return n < 0 ? -longint'(q) : longint'(q);
   endfunction

   task automatic integrate_pose(input odo_request_type r, output odo_pose_type p);
      longint c, s, qc, qs, sc_x, sc_y, hi;
      hi = (longint'(1) <<< (opi_pkg::POS_W - 1)) - 1;
      rotate_angle(track_heading * 65536, c, s);
      sc_x = longint'(r.speed) * c;
      sc_y = -(longint'(r.speed) * s);
      track_x = limit(track_x + travel_step(sc_x, r.elapsed_time), -hi - 1, hi);
      track_y = limit(track_y + travel_step(sc_y, r.elapsed_time), -hi - 1, hi);
      track_heading = r.heading;
      rotate_angle(-longint'(r.heading) * 32768, qc, qs);
      p.pos_x = track_x[31:0];
      p.pos_y = track_y[31:0];
      p.vel_x = 16'(limit(floor_shr(sc_x + 64'sh20000000, 30), -32768, 32767));
      p.vel_y = 16'(limit(floor_shr(sc_y + 64'sh20000000, 30), -32768, 32767));
      p.turn_rate = 16'(limit(-longint'(r.yaw_rate), -32768, 32767));
      p.quat_z = 16'(limit(floor_shr(qs + 64'sh8000, 16), -16384, 16384));
      p.quat_w = 16'(limit(floor_shr(qc + 64'sh8000, 16), -16384, 16384));
   endtask

   task automatic send_request(input odo_request_type r);
      odo_pose_type p;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.speed <= r.speed;
      req_bus.yaw_rate <= r.yaw_rate;
      req_bus.heading <= r.heading;
      req_bus.elapsed_time <= r.elapsed_time;
      do @(posedge clock); while (!req_bus.ready);
      integrate_pose(r, p);
      pending_poses.push_back(p);
   endtask

   function automatic odo_request_type random_request();
      odo_request_type r;
      r.speed = 16'($urandom);
      r.yaw_rate = 16'($urandom);
      r.heading = 16'($urandom);
      r.elapsed_time = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(2000));
      return r;
   endfunction

   // receiver side
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_poses.size() == 0) begin
               $display("%0t unexpected pose pos_x=%0d", $time, rsp_bus.pos_x);
               errors++;
            end else begin
               odo_pose_type e;
               e = pending_poses.pop_front();
               if (e.pos_x !== rsp_bus.pos_x || e.pos_y !== rsp_bus.pos_y ||
                   e.vel_x !== rsp_bus.vel_x || e.vel_y !== rsp_bus.vel_y ||
                   e.turn_rate !== rsp_bus.turn_rate || e.quat_z !== rsp_bus.quat_z ||
                   e.quat_w !== rsp_bus.quat_w) begin
                  $display("%0t expected %0d %0d %0d %0d %0d %0d %0d",
                           $time, e.pos_x, e.pos_y, e.vel_x, e.vel_y, e.turn_rate,
                           e.quat_z, e.quat_w,
                           " actual %0d %0d %0d %0d %0d %0d %0d",
                           rsp_bus.pos_x, rsp_bus.pos_y, rsp_bus.vel_x,
                           rsp_bus.vel_y, rsp_bus.turn_rate, rsp_bus.quat_z,
                           rsp_bus.quat_w);
                  errors++;
               end
            end
         end
         rsp_bus.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      odo_row_type rows[$];
      req_bus.valid = 1'b0;
      req_bus.speed = '0;
      req_bus.yaw_rate = '0;
      req_bus.heading = '0;
      req_bus.elapsed_time = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero request after reset: known pose
      rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'd0}, 1'b1,
                       '{32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384}});
      // most negative yaw rate saturates, heading -pi gives quat_z 16384
      rows.push_back('{'{16'sd0, -16'sd32768, -16'sd32768, 16'd0}, 1'b1,
                       '{32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd32767, 16'sd16384, 16'sd0}});
      rows.push_back('{'{16'sd0, 16'sd32767, 16'sd0, 16'd0}, 1'b0, '{default: 0}});
      rows.push_back('{'{-16'sd32768, 16'sd0, 16'sd0, 16'd65535}, 1'b0, '{default: 0}});
      rows.push_back('{'{16'sd32767, 16'sd1, 16'sd16384, 16'd65535}, 1'b0, '{default: 0}});
      rows.push_back('{'{-16'sd32768, 16'sd0, -16'sd16384, 16'd65535}, 1'b0, '{default: 0}});
      rows.push_back('{'{16'sd32767, -16'sd1, 16'sd32767, 16'd65535}, 1'b0, '{default: 0}});
      rows.push_back('{'{-16'sd32768, 16'sd0, -16'sd32768, 16'd1}, 1'b0, '{default: 0}});
      rows.push_back('{'{16'sd32767, 16'sd0, 16'sd8192, 16'd32768}, 1'b0, '{default: 0}});
      // repeat full-speed requests with the longest elapsed time
      for (int i = 0; i < 12; i++)
         rows.push_back('{'{16'sd32767, 16'sd0, 16'sd0, 16'd65535}, 1'b0, '{default: 0}});

      foreach (rows[i]) begin
         send_request(rows[i].req);
         if (rows[i].known && !same_pose(pending_poses[$], rows[i].pose)) begin
            $display("%0t expected table pose %0d %0d %0d actual prediction %0d %0d %0d",
                     $time, rows[i].pose.turn_rate, rows[i].pose.quat_z,
                     rows[i].pose.quat_w, pending_poses[$].turn_rate,
                     pending_poses[$].quat_z, pending_poses[$].quat_w);
            errors++;
         end
      end

      // long receiver hold-off so the input queue fills
      hold_off = 1'b1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 6; i++) send_request(random_request());
      join

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = ph == 0 ? 15 : (ph == 1 ? 54 : 0);
         recv_idle_pct = ph == 0 ? 54 : (ph == 1 ? 15 : 0);
         for (int i = 0; i < 460; i++) send_request(random_request());
      end
      req_bus.valid <= 1'b0;

      while (pending_poses.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
`default_nettype wire
